>>> rtl/core/sts_pkg.sv
// ============================================================================
// sts_pkg: shared types and constants for the Taylor series sine block
// Holds the control word layout, the microprogram, and the reciprocal table.
// ============================================================================
`default_nettype none

package sts_pkg;

  // Fixed formats of the datapath.
  localparam int FRAC_BITS   = 30;
  localparam int TABLE_TERMS = 12;
  localparam int MAG_W       = 32;  // term magnitude, at most 2^31
  localparam int OP_W        = 34;  // multiplier operand width
  localparam int PROD_W      = 2 * OP_W;
  localparam int ACC_W       = 36;  // exact signed sum of Q.30 terms
  localparam int CNT_W       = 4;
  localparam int PC_W        = 3;

  // Multiplier operand A sources.
  localparam logic [1:0] A_MAG   = 2'd0;  // magnitude of the angle
  localparam logic [1:0] A_RND30 = 2'd1;  // product rounded by 2^30
  localparam logic [1:0] A_RND32 = 2'd2;  // product rounded by 2^32

  // Multiplier operand B sources.
  localparam logic [1:0] B_MAG   = 2'd0;
  localparam logic [1:0] B_RND30 = 2'd1;
  localparam logic [1:0] B_X2    = 2'd2;
  localparam logic [1:0] B_RECIP = 2'd3;

  // Jump conditions of the sequencer.
  localparam logic [1:0] COND_NONE   = 2'd0;
  localparam logic [1:0] COND_ALWAYS = 2'd1;
  localparam logic [1:0] COND_SINGLE = 2'd2;  // only one term requested
  localparam logic [1:0] COND_MORE   = 2'd3;  // further terms remain

  // Program step addresses.
  localparam logic [PC_W-1:0] PC_SQUARE = 3'd0;
  localparam logic [PC_W-1:0] PC_X2     = 3'd1;
  localparam logic [PC_W-1:0] PC_RECIP  = 3'd2;
  localparam logic [PC_W-1:0] PC_TERM   = 3'd3;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd4;

  // One microprogram word.
  typedef struct packed {
    logic [1:0]      a_sel;
    logic [1:0]      b_sel;
    logic            wr_x2;
    logic            wr_term;
    logic            fin;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } prog_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       wr_x2;
    logic       wr_term;
    logic       fin;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic single;
    logic more;
  } status_t;

  // Microprogram ROM.
  function automatic prog_word_t prog_rom(input logic [PC_W-1:0] pc);
    prog_word_t w;
    w = '0;
    unique case (pc)
      PC_SQUARE: begin
        w.a_sel = A_MAG;
        w.b_sel = B_MAG;
      end
      PC_X2: begin
        // Store x^2 and start the first term product.
        w.a_sel  = A_MAG;
        w.b_sel  = B_RND30;
        w.wr_x2  = 1'b1;
        w.cond   = COND_SINGLE;
        w.target = PC_FINISH;
      end
      PC_RECIP: begin
        w.a_sel = A_RND30;
        w.b_sel = B_RECIP;
      end
      PC_TERM: begin
        // Add the new term and start the next term product.
        w.a_sel   = A_RND32;
        w.b_sel   = B_X2;
        w.wr_term = 1'b1;
        w.cond    = COND_MORE;
        w.target  = PC_RECIP;
      end
      PC_FINISH: begin
        w.fin    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_SQUARE;
      end
      default: begin
        w.fin    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_SQUARE;
      end
    endcase
    return w;
  endfunction

  // Reciprocals round(2^32 / (2k(2k+1))), indexed by k-1.
  function automatic logic [OP_W-1:0] recip_rom(input logic [CNT_W-1:0] idx);
    logic [OP_W-1:0] r;
    unique case (idx)
      4'd0:    r = 34'd715827883;
      4'd1:    r = 34'd214748365;
      4'd2:    r = 34'd102261126;
      4'd3:    r = 34'd59652324;
      4'd4:    r = 34'd39045157;
      4'd5:    r = 34'd27531842;
      4'd6:    r = 34'd20452225;
      4'd7:    r = 34'd15790321;
      4'd8:    r = 34'd12558384;
      4'd9:    r = 34'd10226113;
      4'd10:   r = 34'd8488078;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sts_sequencer.sv
// ============================================================================
// sts_sequencer: microprogram sequencer
// Steps a program counter through the control ROM, with conditional jumps
// taken on datapath status, and tracks whether an item is in progress.
// ============================================================================
`default_nettype none

module sts_sequencer
  import sts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  var  status_t status,
  output var  ctrl_t   ctrl,
  output logic         busy
);

  logic [PC_W-1:0] pc;
  prog_word_t      word;
  logic            take;

  assign word = prog_rom(pc);

  // Jump condition decode.
  always_comb begin
    unique case (word.cond)
      COND_NONE:   take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_SINGLE: take = status.single;
      COND_MORE:   take = status.more;
      default:     take = 1'b0;
    endcase
  end

  // Control word to the datapath; while idle only load can be raised.
  always_comb begin
    ctrl         = '0;
    ctrl.load    = start && !busy;
    ctrl.mul_en  = busy;
    ctrl.a_sel   = word.a_sel;
    ctrl.b_sel   = word.b_sel;
    ctrl.wr_x2   = busy && word.wr_x2;
    ctrl.wr_term = busy && word.wr_term;
    ctrl.fin     = busy && word.fin;
  end

  // Program counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_SQUARE;
    end else if (start && !busy) begin
      busy <= 1'b1;
      pc   <= PC_SQUARE;
    end else if (busy) begin
      pc <= take ? word.target : pc + 3'd1;
      if (word.fin) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sts_datapath.sv
// ============================================================================
// sts_datapath: shared multiplier datapath
// One registered multiplier, rounding shifters, term accumulator and the
// final saturation with its output register.
// ============================================================================
`default_nettype none

module sts_datapath
  import sts_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  var  ctrl_t            ctrl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [31:0]      angle,
  output var  status_t          status,
  output logic                  done,
  output logic [31:0]           sine,
  output logic                  overflow
);

  localparam int WIDE_W = 65;
  localparam logic signed [WIDE_W-1:0] SAT_HI =
    (WIDE_W'(1) <<< (DATA_WIDTH - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);
  localparam logic [31:0] OUT_MASK = (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << DATA_WIDTH) - 64'd1);

  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic [OP_W-1:0]         x2;
  logic [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0] acc;
  logic [CNT_W-1:0]        k;

  logic [PROD_W-1:0]       sum30;
  logic [PROD_W-1:0]       sum32;
  logic [OP_W-1:0]         rnd30;
  logic [MAG_W-1:0]        rnd32;
  logic [OP_W-1:0]         a_op;
  logic [OP_W-1:0]         b_op;
  logic [CNT_W:0]          k_inc;
  logic                    tneg;
  logic signed [WIDE_W-1:0] wide;
  logic signed [WIDE_W-1:0] sat;
  logic                    sat_flag;

  // Round half up after the shift back to Q.30.
  assign sum30 = prod + (PROD_W'(1) << (FRAC_BITS - 1));
  assign sum32 = prod + (PROD_W'(1) << 31);
  assign rnd30 = sum30[FRAC_BITS +: OP_W];
  assign rnd32 = sum32[32 +: MAG_W];

  // Multiplier operand selection.
  always_comb begin
    unique case (ctrl.a_sel)
      A_MAG:   a_op = OP_W'(mag);
      A_RND30: a_op = rnd30;
      A_RND32: a_op = OP_W'(rnd32);
      default: a_op = OP_W'(mag);
    endcase
    unique case (ctrl.b_sel)
      B_MAG:   b_op = OP_W'(mag);
      B_RND30: b_op = rnd30;
      B_X2:    b_op = x2;
      B_RECIP: b_op = recip_rom(k - 4'd1);
      default: b_op = OP_W'(mag);
    endcase
  end

  // Term status for the sequencer.
  assign k_inc         = {1'b0, k} + 5'd1;
  assign status.single = (count == 4'd1);
  assign status.more   = (k_inc < {1'b0, count});
  assign tneg          = neg ^ k[0];

  // Working registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= angle[31] ? 32'd0 - angle : angle;
      neg <= angle[31];
      acc <= ACC_W'($signed(angle));
      k   <= 4'd1;
    end else begin
      if (ctrl.mul_en) begin
        prod <= a_op * b_op;
      end
      if (ctrl.wr_x2) begin
        x2 <= rnd30;
      end
      if (ctrl.wr_term) begin
        if (tneg) begin
          acc <= acc - $signed({{(ACC_W - MAG_W){1'b0}}, rnd32});
        end else begin
          acc <= acc + $signed({{(ACC_W - MAG_W){1'b0}}, rnd32});
        end
        k <= k_inc[CNT_W-1:0];
      end
    end
  end

  // Saturation to the signed output range.
  assign wide = WIDE_W'(acc);
  always_comb begin
    priority if (wide > SAT_HI) begin
      sat      = SAT_HI;
      sat_flag = 1'b1;
    end else if (wide < SAT_LO) begin
      sat      = SAT_LO;
      sat_flag = 1'b1;
    end else begin
      sat      = wide;
      sat_flag = 1'b0;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      sine     <= sat[31:0] & OUT_MASK;
      overflow <= sat_flag;
    end
  end

  // The term index never runs past the reciprocal table.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_term |-> (k < CNT_W'(TABLE_TERMS)))
    else $error("term index beyond reciprocal table");

endmodule

`default_nettype wire

>>> rtl/core/sine_taylor_series.sv
// ============================================================================
// sine_taylor_series: Taylor series sine in signed Q1.30
// Top level with the term count register, sequencer and datapath.
// ============================================================================
// Usage:
//   An angle is transferred in at a rising edge where start is high and busy
//   is low. busy stays high until the result is out; start is ignored then.
//   The result (sine, overflow) is shown for one cycle with done high and is
//   taken at the edge that ends that cycle; the receiver cannot stall.
//   busy drops as done rises, so a new angle may be transferred at the edge
//   that takes the result. The time from one start to the next is set by the
//   single shared multiplier: the microprogram steps through the squaring,
//   the x^2 store, two multiplies for each term after the first, and the
//   finish step, before the result is shown.
//   term_count is written over the cfg channel (cfg_valid, cfg_ready always
//   high, cfg_data); the user must write it only while the block is idle, as
//   the block itself does not enforce it. Zero acts as one term and values
//   above the term limit act as the limit.
//   Reset clears busy and done, and sets term_count to 3.
// ============================================================================
`default_nettype none

module sine_taylor_series
  import sts_pkg::*;
#(
  parameter int MAX_TERMS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] angle,
  output logic             done,
  output logic [31:0]      sine,
  output logic             overflow,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int LIMIT = (MAX_TERMS > TABLE_TERMS) ? TABLE_TERMS :
                         ((MAX_TERMS < 1) ? 1 : MAX_TERMS);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIMIT);

  logic [CNT_W-1:0] term_count;
  logic [CNT_W-1:0] count;
  ctrl_t            ctrl;
  status_t          status;

  // Configuration register transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      term_count <= cfg_data;
    end
  end

  // Effective number of terms.
  always_comb begin
    priority if (term_count == 4'd0) begin
      count = 4'd1;
    end else if (term_count > LIMIT_CNT) begin
      count = LIMIT_CNT;
    end else begin
      count = term_count;
    end
  end

  sts_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  sts_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .count    (count),
    .angle    (angle),
    .status   (status),
    .done     (done),
    .sine     (sine),
    .overflow (overflow)
  );

  // An accepted angle keeps the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted angle did not raise busy");

  // The result strobe lasts one cycle.
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A result appears only once the item is finished.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done without a finished item");

endmodule

`default_nettype wire

>>> sim/sine_taylor_series_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// sine_taylor_series_tb: self-checking bench for the Taylor series sine block
// Angles are sent through the start/busy handshake and every sine/overflow
// result is checked against a fixed-point Taylor sum computed in the bench.
// The term count register is rewritten between phases, extremes included.
// ============================================================================

module sine_taylor_series_tb;

  localparam int TERM_LIMIT  = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 24;  // idle wait after all work has drained
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 120;

  // One queued job: either an angle or a term count write.
  typedef struct {
    bit              is_cfg;
    logic [31:0]     angle;
    logic [3:0]      count;
    int unsigned     gap;
    bit              early;  // raise start again while the block is busy
  } sine_job_t;

  // Expected result of one angle.
  typedef struct {
    logic [31:0] angle;
    logic [31:0] sine;
    logic        overflow;
  } sine_expect_t;

  logic clk;
  logic rst = 1'b1;

  logic        start = 1'b0;
  logic [31:0] angle = '0;
  logic        cfg_valid = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        busy;
  logic        done;
  logic [31:0] sine;
  logic        overflow;
  logic        cfg_ready;

  sine_job_t    sine_jobs[$];
  sine_expect_t sine_expected[$];

  logic [3:0]  term_count_now;
  bit          awaiting_result;
  int unsigned hold_cycles;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  sine_taylor_series #(
    .MAX_TERMS (TERM_LIMIT),
    .DATA_WIDTH(32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .angle    (angle),
    .done     (done),
    .sine     (sine),
    .overflow (overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Free-running 2 ns clock.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Alternating Taylor sum with the block's rounding: magnitudes are kept
  // unsigned, each step rounds half up, and the wide sum is clamped at the end.
  function automatic sine_expect_t taylor_sine(input logic [31:0] x,
                                               input logic [3:0] count_reg);
    sine_expect_t res;
    logic [63:0]  mag;
    logic [63:0]  x_sq;
    logic [63:0]  prod;
    logic [63:0]  recip;
    logic [63:0]  denom;
    longint       acc;
    int           terms;
    bit           neg;
    neg   = x[31];
    mag   = neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
    acc   = neg ? -longint'(mag) : longint'(mag);
    terms = count_reg;
    if (terms < 1) terms = 1;
    if (terms > TERM_LIMIT) terms = TERM_LIMIT;
    x_sq = (mag * mag + (64'd1 << 29)) >> 30;
    for (int k = 1; k < terms; k++) begin
      // Reciprocal of 2k(2k+1) in Q0.32, rounded to nearest.
      denom = 64'(2 * k * (2 * k + 1));
      recip = ((64'd1 << 32) + denom / 2) / denom;
      prod  = (mag * x_sq + (64'd1 << 29)) >> 30;
      mag   = (prod * recip + (64'd1 << 31)) >> 32;
      if (neg ^ k[0]) acc = acc - longint'(mag);
      else acc = acc + longint'(mag);
    end
    res.angle    = x;
    res.overflow = 1'b0;
    if (acc > 64'sd2147483647) begin
      acc          = 64'sd2147483647;
      res.overflow = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      acc          = -64'sd2147483648;
      res.overflow = 1'b1;
    end
    res.sine = acc[31:0];
    return res;
  endfunction

  task automatic add_angle(input logic [31:0] a, input int unsigned gap, input bit early);
    sine_job_t job;
    job.is_cfg = 1'b0;
    job.angle  = a;
    job.count  = '0;
    job.gap    = gap;
    job.early  = early;
    sine_jobs.push_back(job);
  endtask

  task automatic add_count(input logic [3:0] c);
    sine_job_t job;
    job.is_cfg = 1'b1;
    job.angle  = '0;
    job.count  = c;
    job.gap    = $urandom_range(0, 3);
    job.early  = 1'b0;
    sine_jobs.push_back(job);
  endtask

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", what);
  endtask

  // Driver: takes jobs from the queue, predicts each accepted angle and
  // tracks the term count as writes complete.
  always @(posedge clk) begin
    sine_job_t job;
    logic      start_nx;
    logic      cfg_valid_nx;
    start_nx     = start;
    cfg_valid_nx = cfg_valid;
    if (rst) begin
      start_nx        = 1'b0;
      cfg_valid_nx    = 1'b0;
      term_count_now  = 4'd3;
      awaiting_result = 1'b0;
      hold_cycles     = 0;
    end else begin
      if (done) awaiting_result = 1'b0;
      // Angle transfer.
      if (start && !busy) begin
        sine_expected.push_back(taylor_sine(angle, term_count_now));
        awaiting_result = 1'b1;
        start_nx        = 1'b0;
      end
      // Register write transfer.
      if (cfg_valid && cfg_ready) begin
        term_count_now = cfg_data;
        cfg_valid_nx   = 1'b0;
      end
      if (!start_nx && !cfg_valid_nx && sine_jobs.size() > 0) begin
        job = sine_jobs[0];
        if (hold_cycles > 0 && !(job.early && !job.is_cfg)) begin
          if (!awaiting_result) hold_cycles--;
        end else if (job.is_cfg) begin
          // Writes only go out once the block has nothing left to deliver.
          if (!awaiting_result && !busy) begin
            cfg_valid_nx = 1'b1;
            cfg_data    <= job.count;
            hold_cycles  = job.gap;
            void'(sine_jobs.pop_front());
          end
        end else begin
          start_nx    = 1'b1;
          angle      <= job.angle;
          hold_cycles = job.gap;
          void'(sine_jobs.pop_front());
        end
      end
    end
    start     <= start_nx;
    cfg_valid <= cfg_valid_nx;
  end

  // Monitor: every done cycle carries one result, checked against the
  // oldest prediction.
  always @(posedge clk) begin
    sine_expect_t want;
    if (!rst && done) begin
      if (sine_expected.size() == 0) begin
        note_failure($sformatf("result with nothing expected: sine=%h overflow=%b",
                               sine, overflow));
      end else begin
        want = sine_expected.pop_front();
        if (sine !== want.sine)
          note_failure($sformatf("angle %h: sine expected %h, got %h",
                                 want.angle, want.sine, sine));
        if (overflow !== want.overflow)
          note_failure($sformatf("angle %h: overflow expected %b, got %b",
                                 want.angle, want.overflow, overflow));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] a;
    logic [3:0]  cnt;
    int unsigned pick;
    int unsigned gap;
    bit          early;
    bit          timed_out;

    // Directed angles at the reset term count: zero, smallest steps,
    // both range ends, plus and minus one, plus and minus pi/2, bit patterns.
    add_angle(32'h0000_0000, 0, 0);
    add_angle(32'h0000_0001, 1, 0);
    add_angle(32'hFFFF_FFFF, 0, 1);
    add_angle(32'h7FFF_FFFF, 2, 0);
    add_angle(32'h8000_0000, 0, 0);
    add_angle(32'h4000_0000, 3, 0);
    add_angle(32'hC000_0000, 0, 1);
    add_angle(32'h6487_ED51, 0, 0);
    add_angle(32'h9B78_12AF, 1, 0);
    add_angle(32'h0000_8000, 0, 0);
    add_angle(32'hAAAA_AAAA, 0, 0);
    add_angle(32'h5555_5555, 2, 1);
    // Term count at the term limit.
    add_count(4'd8);
    add_angle(32'h8000_0000, 0, 0);
    add_angle(32'h7FFF_FFFF, 0, 1);
    add_angle(32'h6487_ED51, 1, 0);
    add_angle(32'h9B78_12AF, 0, 0);
    // Zero term count acts as a single term.
    add_count(4'd0);
    add_angle(32'h8000_0000, 0, 0);
    add_angle(32'h7FFF_FFFF, 3, 0);
    add_angle(32'h1234_5678, 0, 0);
    // Counts above the term limit are clamped.
    add_count(4'd15);
    add_angle(32'h8000_0001, 0, 0);
    add_angle(32'h6487_ED51, 0, 1);
    add_angle(32'h4000_0000, 0, 0);

    // Random phases, each with its own term count; some run without gaps.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       cnt = 4'd1;
        1:       cnt = 4'd8;
        2:       cnt = 4'd9;
        3:       cnt = 4'd0;
        4:       cnt = 4'd2;
        5:       cnt = 4'd7;
        default: cnt = 4'($urandom_range(0, 15));
      endcase
      add_count(cnt);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          a = $urandom;
        end else if (pick <= 7) begin
          a = 32'($urandom_range(0, 4095)) - 32'd2048;
        end else if (pick == 8) begin
          a = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
        end else begin
          case ($urandom_range(0, 3))
            0:       a = 32'h8000_0000;
            1:       a = 32'h7FFF_FFFF;
            2:       a = 32'h8000_0001;
            default: a = 32'h6487_ED51;
          endcase
        end
        gap   = (p % 4 == 1) ? 0 : $urandom_range(0, 3);
        early = ($urandom_range(0, 6) == 0);
        add_angle(a, gap, early);
      end
    end
    add_count(4'd3);
    add_angle($urandom, 0, 0);

    // Hold reset at the start, then release it.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for all work to drain, bounded by the cycle limit.
    while (!(sine_jobs.size() == 0 && !start && !cfg_valid && !awaiting_result &&
             sine_expected.size() == 0) && cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (cycle_count >= CYCLE_LIMIT);
    if (!timed_out) repeat (DRAIN_WAIT) @(posedge clk);

    if (timed_out) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
    end else if (mismatch_count == 0 && sine_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sine_expected.size() != 0)
        $display("ERROR: %0d results never arrived", sine_expected.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sts_pkg.sv
rtl/core/sts_sequencer.sv
rtl/core/sts_datapath.sv
rtl/core/sine_taylor_series.sv
sim/sine_taylor_series_tb.sv
